>>> rtl/lwbc_pkg.sv
// Shared types and constants for the LRU write-back cache core.
`default_nettype none

package lwbc_pkg;

    localparam int ADDR_W     = 10;
    localparam int DATA_W     = 32;
    localparam int CAP_W      = 4;
    localparam int MWORDS_W   = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam int CACHE_ENTRIES_DEF = 8;
    localparam int MEMORY_DEPTH_DEF  = 1024;

    localparam logic [CAP_W-1:0]    CAP_RESET    = 4'd8;
    localparam logic [MWORDS_W-1:0] MWORDS_RESET = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_WORDS   = 1'b1;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOB = 1'b1;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic lookup;
        logic update;
    } lwbc_cmd_t;

    typedef struct packed {
        logic clear_last;
    } lwbc_stat_t;

endpackage

`default_nettype wire

>>> rtl/lwbc_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module lwbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[addr] <= wdata;
        end
        rdata_reg <= ram_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/lwbc_ctrl.sv
// Controller state machine: memory clearing pass, request accept, lookup and update.
`default_nettype none

module lwbc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    output logic                    done,
    output lwbc_pkg::lwbc_cmd_t     cmd,
    input  wire lwbc_pkg::lwbc_stat_t stat
);

    import lwbc_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_UPD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= (state_reg == S_UPD);
        end
    end

    assign cmd.clear_step = (state_reg == S_CLEAR);
    assign cmd.capture    = (state_reg == S_IDLE) && start;
    assign cmd.lookup     = (state_reg == S_LOOK);
    assign cmd.update     = (state_reg == S_UPD);

    assign busy = busy_reg;
    assign done = done_reg;

`ifndef SYNTHESIS
    a_upd_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |=> done_reg)
        else $error("update without result strobe");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result strobe while busy");
`endif

endmodule

`default_nettype wire

>>> rtl/lwbc_dp.sv
// Datapath: config registers, cache entries with LRU ranks, backing memory and result registers.
`default_nettype none

module lwbc_dp #(
    parameter int CACHE_ENTRIES = lwbc_pkg::CACHE_ENTRIES_DEF,
    parameter int MEMORY_DEPTH  = lwbc_pkg::MEMORY_DEPTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire lwbc_pkg::lwbc_cmd_t                  cmd,
    output lwbc_pkg::lwbc_stat_t                      stat,
    input  wire logic                                 action,
    input  wire logic [lwbc_pkg::ADDR_W-1:0]          address,
    input  wire logic signed [lwbc_pkg::DATA_W-1:0]   write_value,
    input  wire logic                                 cfg_valid,
    input  wire logic [lwbc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lwbc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic signed [lwbc_pkg::DATA_W-1:0]        read_value,
    output logic                                      status
);

    import lwbc_pkg::*;

    localparam int CW = $clog2(CACHE_ENTRIES + 1);
    localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int AW = $clog2(MEMORY_DEPTH);

    function automatic logic [AW-1:0] to_ram_idx(input logic [ADDR_W-1:0] a);
        logic [AW+ADDR_W-1:0] ext;
        ext = {{AW{1'b0}}, a};
        return ext[AW-1:0];
    endfunction

    logic [CAP_W-1:0]    cap_reg;
    logic [MWORDS_W-1:0] mwords_reg;

    logic              action_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] wdata_reg;

    logic [ADDR_W-1:0] entry_addr_reg [CACHE_ENTRIES];
    logic [DATA_W-1:0] entry_val_reg  [CACHE_ENTRIES];
    logic [IW-1:0]     age_reg        [CACHE_ENTRIES];
    logic [CW-1:0]     used_reg;

    logic [IW-1:0] slot_reg;
    logic          hit_reg;
    logic          evict_reg;
    logic          oob_reg;

    logic [AW-1:0] clr_cnt_reg;

    logic [DATA_W-1:0] read_value_reg;
    logic              status_reg;

    logic [CACHE_ENTRIES-1:0] match;
    logic [CACHE_ENTRIES-1:0] lru;
    logic [IW-1:0]            hit_idx;
    logic [IW-1:0]            lru_idx;
    logic                     hit;
    logic                     need_evict;
    logic [IW-1:0]            slot_sel;
    logic [CW-1:0]            cap_eff;
    logic [31:0]              mem_limit;
    logic                     oob;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    logic [DATA_W-1:0] fill_value;
    logic [IW-1:0]     old_age;
    logic [CW-1:0]     used_new;
    logic              wb_in_range;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_RESET;
            mwords_reg <= MWORDS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CACHE_CAPACITY: cap_reg    <= cfg_data[CAP_W-1:0];
                CFG_MEMORY_WORDS:   mwords_reg <= cfg_data[MWORDS_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            addr_reg   <= address;
            wdata_reg  <= write_value;
        end
    end

    // Lookup
    always_comb
    begin
        hit_idx = '0;
        lru_idx = '0;
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            match[i] = (CW'(i) < used_reg) && (entry_addr_reg[i] == addr_reg);
            lru[i]   = (CW'(i) < used_reg) && (age_reg[i] == IW'(used_reg - CW'(1)));
        end
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = IW'(i);
            end
            if (lru[i])
            begin
                lru_idx = IW'(i);
            end
        end
    end

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (32'(cap_reg) > 32'(CACHE_ENTRIES))
        begin
            cap_eff = CW'(CACHE_ENTRIES);
        end
        else
        begin
            cap_eff = CW'(cap_reg);
        end
    end

    assign mem_limit  = (32'(mwords_reg) > 32'(MEMORY_DEPTH)) ? 32'(MEMORY_DEPTH)
                                                              : 32'(mwords_reg);
    assign oob        = (32'(addr_reg) >= mem_limit);
    assign hit        = |match;
    assign need_evict = !hit && (used_reg >= cap_eff);
    assign slot_sel   = hit ? hit_idx : (need_evict ? lru_idx : IW'(used_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            hit_reg   <= 1'b0;
            evict_reg <= 1'b0;
            oob_reg   <= 1'b0;
        end
        else if (cmd.lookup)
        begin
            slot_reg  <= slot_sel;
            hit_reg   <= hit;
            evict_reg <= need_evict;
            oob_reg   <= oob;
        end
    end

    // Backing memory
    assign wb_in_range = (32'(entry_addr_reg[slot_reg]) < 32'(MEMORY_DEPTH));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = to_ram_idx(addr_reg);
        ram_wdata = entry_val_reg[slot_reg];
        if (cmd.clear_step)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (cmd.update)
        begin
            ram_we   = evict_reg && !oob_reg && wb_in_range;
            ram_addr = to_ram_idx(entry_addr_reg[slot_reg]);
        end
    end

    lwbc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEMORY_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    assign stat.clear_last = (clr_cnt_reg == AW'(MEMORY_DEPTH - 1));

    // Update
    assign fill_value = (action_reg == ACT_WRITE) ? wdata_reg
                      : (hit_reg ? entry_val_reg[slot_reg] : ram_rdata);
    assign old_age    = (hit_reg || evict_reg) ? age_reg[slot_reg] : IW'(used_reg);
    assign used_new   = (!hit_reg && !evict_reg) ? used_reg + CW'(1) : used_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.update && !oob_reg)
        begin
            entry_addr_reg[slot_reg] <= addr_reg;
            entry_val_reg[slot_reg]  <= fill_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else if (cmd.update && !oob_reg)
        begin
            used_reg <= used_new;
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                if (IW'(i) == slot_reg)
                begin
                    age_reg[i] <= '0;
                end
                else if ((CW'(i) < used_new) && (age_reg[i] < old_age))
                begin
                    age_reg[i] <= age_reg[i] + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            read_value_reg <= (oob_reg || (action_reg == ACT_WRITE)) ? '0 : fill_value;
            status_reg     <= oob_reg ? STATUS_OOB : STATUS_OK;
        end
    end

    assign read_value = read_value_reg;
    assign status     = status_reg;

`ifndef SYNTHESIS
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |-> $onehot0(match))
        else $error("address held by more than one entry");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(CACHE_ENTRIES))
        else $error("entry count above built size");

    a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && !oob_reg && !hit_reg && !evict_reg)
        |=> (used_reg == CW'($past(used_reg) + CW'(1))))
        else $error("fill did not grow entry count");
`endif

endmodule

`default_nettype wire

>>> rtl/lru_write_back_cache_core.sv
// Top level of the fully associative LRU write-back cache core.
// After acceptance a request passes lookup then update, and done is registered from update.
// A new request is taken only while idle, after the last one has passed lookup and update.
// Reset: a clearing pass zeroes all MEMORY_DEPTH words of backing memory (1024 by default),
// with busy high; config writes are taken at all times.
// Results hold until the next update, with done high one cycle; the receiver cannot stall.
`default_nettype none

module lru_write_back_cache_core #(
    parameter int CACHE_ENTRIES = lwbc_pkg::CACHE_ENTRIES_DEF,
    parameter int MEMORY_DEPTH  = lwbc_pkg::MEMORY_DEPTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 action,
    input  wire logic [lwbc_pkg::ADDR_W-1:0]          address,
    input  wire logic signed [lwbc_pkg::DATA_W-1:0]   write_value,
    output logic                                      done,
    output logic signed [lwbc_pkg::DATA_W-1:0]        read_value,
    output logic                                      status,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [lwbc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lwbc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import lwbc_pkg::*;

    lwbc_cmd_t  cmd;
    lwbc_stat_t stat;

    assign cfg_ready = 1'b1;

    lwbc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    lwbc_dp #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .MEMORY_DEPTH  (MEMORY_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (action),
        .address     (address),
        .write_value (write_value),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .read_value  (read_value),
        .status      (status)
    );

endmodule

`default_nettype wire
